// ===== src/segtree_pkg.sv =====
`default_nettype none

package segtree_pkg;

	// field widths of the stream beats and the leaf count register
	localparam int POS_W  = 11;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 11;

	// input beat: position, new_value, range_start, range_end, padded to bytes
	localparam int IN_FIELDS_W = POS_W + VAL_W + POS_W + POS_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// operation codes carried in tuser
	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// leaf count after reset
	localparam int CNT_RESET = 1024;

endpackage

`default_nettype wire

// ===== src/segment_tree_point_update_range_sum_unit.sv =====
`default_nettype none

// Segment tree of 32-bit wrapping sums with point update and range-sum query.
// Input stream s_*: tuser carries the operation (set or query), tdata carries
// position, new_value, range_start and range_end. A set gives no output beat;
// a query gives one beat on m_* with the sum over [range_start, range_end).
// Sums live in one simple dual-port RAM of 2*2^clog2(MAX_LEAVES) words with a
// registered read; a small sequencer and two 32-bit adders walk the tree.
// After acceptance an item walks the tree:
//   set:   one sibling read and one parent write a level, up to the root
//   query: one ST_QA step and one ST_QB step a tree level
// with span the leaf count rounded up to a power of two; a set outside the
// span ends at acceptance with no walk.
// s_tready is high only while the sequencer is idle. A finished query sits in
// the output register until m_tready takes it; the next item is accepted
// meanwhile, and a query that finishes while that register is full waits.
// Reset and every cfg_we write start a clearing pass that zeroes every RAM
// word, one a cycle, with s_tready low; a new leaf count takes effect at once.
module segment_tree_point_update_range_sum_unit
	import segtree_pkg::*;
#(
	parameter int MAX_LEAVES = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [10:0] position, [42:11] new_value, [53:43] range_start,
	// [64:54] range_end, [71:65] zero
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	// [0] operation
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [31:0] range_sum
	output logic      [VAL_W-1:0]     m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic [CNT_W-1:0]     cfg_wdata
);

	localparam int LW    = $clog2(MAX_LEAVES);
	localparam int SW    = LW + 1;
	localparam int NW    = LW + 1;
	localparam int QW    = LW + 2;
	localparam int DEPTH = 2 << LW;
	localparam int XW    = (QW > POS_W + 1) ? QW : POS_W + 1;

	localparam logic [XW-1:0] MAX_X = XW'(MAX_LEAVES);
	localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_QA   = 3'd3;
	localparam logic [2:0] ST_QB   = 3'd4;

	// clamp a leaf count to 1..MAX_LEAVES and round it up to a power of two
	function automatic logic [SW-1:0] span_of(input logic [CNT_W-1:0] cnt);
		logic [XW-1:0] n;
		logic [XW-1:0] m;
		logic [XW-1:0] p;
		n = XW'(cnt);
		if (n == '0) begin
			n = XW'(1);
		end
		if (n > MAX_X) begin
			n = MAX_X;
		end
		m = n - XW'(1);
		p = XW'(1);
		for (int i = 0; i < XW - 1; i++) begin
			if (m[i]) begin
				p = XW'(1) << (i + 1);
			end
		end
		return p[SW-1:0];
	endfunction

	localparam logic [SW-1:0] SPAN_RESET = span_of(CNT_W'(CNT_RESET));

	logic [2:0]       state_q;
	logic [SW-1:0]    span_q;
	logic [NW-1:0]    clr_q;
	logic [NW-1:0]    node_q;
	logic [VAL_W-1:0] cur_q;
	logic [QW-1:0]    lo_q;
	logic [QW-1:0]    hi_q;
	logic [VAL_W-1:0] sum_q;
	logic             pend_q;
	logic             m_tvalid_q;
	logic [VAL_W-1:0] m_tdata_q;

	logic             ram_we;
	logic [NW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [NW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	// unpack the input beat
	logic             in_op;
	logic [POS_W-1:0] in_pos;
	logic [VAL_W-1:0] in_val;
	logic [POS_W-1:0] in_rs;
	logic [POS_W-1:0] in_re;

	assign in_op  = s_tuser;
	assign in_pos = s_tdata[POS_W-1:0];
	assign in_val = s_tdata[POS_W+VAL_W-1:POS_W];
	assign in_rs  = s_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W];
	assign in_re  = s_tdata[3*POS_W+VAL_W-1:2*POS_W+VAL_W];

	logic in_fire;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// leaf node of an update and its validity
	logic [XW-1:0] span_x;
	logic [XW-1:0] pos_x;
	logic          pos_ok;
	logic [NW-1:0] leaf_node;

	assign span_x    = XW'(span_q);
	assign pos_x     = XW'(in_pos);
	assign pos_ok    = (pos_x != '0) && (pos_x <= span_x);
	assign leaf_node = NW'(pos_x + span_x - XW'(1));

	// clip the query bounds and map them onto node indices
	logic [XW-1:0] rs_x;
	logic [XW-1:0] re_x;
	logic [XW-1:0] lo_pos;
	logic [XW-1:0] hi_pos;
	logic [XW-1:0] lo_clip;
	logic [QW-1:0] lo_init;
	logic [QW-1:0] hi_init;

	always_comb begin
		rs_x    = XW'(in_rs);
		re_x    = XW'(in_re);
		lo_pos  = (rs_x == '0) ? XW'(1) : rs_x;
		hi_pos  = (re_x > span_x + XW'(1)) ? span_x + XW'(1) : re_x;
		lo_clip = (lo_pos > hi_pos) ? hi_pos : lo_pos;
		lo_init = QW'(lo_clip + span_x - XW'(1));
		hi_init = QW'(hi_pos + span_x - XW'(1));
	end

	// parent step of an update
	logic [VAL_W-1:0] up_sum;
	logic [NW-1:0]    up_parent;
	logic             up_more;

	assign up_sum    = cur_q + ram_rdata;
	assign up_parent = node_q >> 1;
	assign up_more   = (up_parent[NW-1:1] != '0);

	logic q_empty;
	logic q_finish;

	assign q_empty  = (lo_q >= hi_q);
	assign q_finish = (state_q == ST_QA) && q_empty && !pend_q && out_free;

	// drive the RAM ports from the sequencer
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = node_q ^ NW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && in_op == OP_SET && pos_ok) begin
					ram_we    = 1'b1;
					ram_waddr = leaf_node;
					ram_wdata = in_val;
					ram_re    = (leaf_node[NW-1:1] != '0);
					ram_raddr = leaf_node ^ NW'(1);
				end
			end
			ST_CLR: begin
				ram_we = !cfg_we;
			end
			ST_UPD: begin
				ram_we    = 1'b1;
				ram_waddr = up_parent;
				ram_wdata = up_sum;
				ram_re    = up_more;
				ram_raddr = up_parent ^ NW'(1);
			end
			ST_QA: begin
				ram_re    = !q_empty && lo_q[0];
				ram_raddr = lo_q[NW-1:0];
			end
			ST_QB: begin
				ram_re    = hi_q[0];
				ram_raddr = {hi_q[NW-1:1], 1'b0};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	segtree_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer: clear, update walk, query walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			span_q  <= SPAN_RESET;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else if (cfg_we) begin
			state_q <= ST_CLR;
			span_q  <= span_of(cfg_wdata);
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_op == OP_QUERY) begin
							state_q <= ST_QA;
						end else if (pos_ok && leaf_node[NW-1:1] != '0) begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_UPD: begin
					if (!up_more) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QA: begin
					if (q_finish) begin
						state_q <= ST_IDLE;
					end else if (!q_empty) begin
						state_q <= ST_QB;
					end
				end
				ST_QB: begin
					state_q <= ST_QA;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk registers and accumulator
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				node_q <= leaf_node;
				cur_q  <= in_val;
				lo_q   <= lo_init;
				hi_q   <= hi_init;
				sum_q  <= '0;
			end
			ST_UPD: begin
				node_q <= up_parent;
				cur_q  <= up_sum;
			end
			ST_QA: begin
				if (pend_q) begin
					sum_q <= sum_q + ram_rdata;
				end
				if (!q_empty && lo_q[0]) begin
					lo_q <= lo_q + QW'(1);
				end
			end
			ST_QB: begin
				if (pend_q) begin
					sum_q <= sum_q + ram_rdata;
				end
				lo_q <= lo_q >> 1;
				hi_q <= hi_q >> 1;
			end
			default: begin
				node_q <= node_q;
			end
		endcase
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (q_finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_finish) begin
			m_tdata_q <= sum_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// the active span is always a single power of two
	a_span_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(span_q))
		else $error("leaf span is not a power of two");

	// a leaf count write restarts the clearing pass from the first word
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == ST_CLR) && (clr_q == '0))
		else $error("leaf count write did not restart the clear");

	// the update walk only runs on nodes that still have a parent
	a_upd_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (node_q[NW-1:1] != '0))
		else $error("update walk passed the root");

	// query bounds never cross while the walk runs
	a_query_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QA || state_q == ST_QB) |-> (lo_q <= hi_q))
		else $error("query bounds crossed");

	// a finished query never overwrites a beat that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !q_finish)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/segtree_ram.sv =====
`default_nettype none

module segtree_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== tb/segment_tree_point_update_range_sum_unit_tb.sv =====
module segment_tree_point_update_range_sum_unit_tb;
	import segtree_pkg::*;

	localparam int CLK_HALF   = 6;
	localparam int TAIL_WAIT  = 40;
	localparam int LONG_HOLD  = 400;
	localparam int TREE_WORDS = 2048;
	localparam int N_PHASES   = 9;

	// one input beat plus an optional hand-written sum
	typedef struct {
		logic             op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		bit               typed;
		logic [VAL_W-1:0] sum;
	} seg_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [VAL_W-1:0]     m_tdata;
	logic                 cfg_we;
	logic [CNT_W-1:0]     cfg_wdata;

	// mirror of the tree and the active span
	logic [VAL_W-1:0] mirror_nodes [TREE_WORDS];
	int               mirror_span;
	logic [VAL_W-1:0] pending_sums [$];

	int idle_pct;
	int stall_pct;
	bit long_hold_req;
	int n_fail;
	int n_sets;
	int n_queries;
	int n_checked;
	int n_cfg;

	seg_req_t dir_rows [$];

	int ph_lc    [N_PHASES] = '{1024, 0, 2047, 1, 3, 1025, -1, 16, 100};
	int ph_items [N_PHASES] = '{300, 80, 250, 60, 150, 200, 200, 150, 150};
	int ph_idle  [N_PHASES] = '{0, 75, 0, 14, 14, 0, 75, 0, 14};
	int ph_stall [N_PHASES] = '{0, 0, 75, 14, 14, 0, 0, 75, 14};

	segment_tree_point_update_range_sum_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// hard stop if the block hangs
	initial begin
		#(2 * CLK_HALF * 1000000);
		$display("TEST FAILED");
		$finish;
	end

	// round the leaf count up to a power of two and clear every sum
	function automatic void load_leaf_count(input logic [CNT_W-1:0] cnt);
		int n;
		n = int'(cnt);
		if (n < 1)
			n = 1;
		if (n > CNT_RESET)
			n = CNT_RESET;
		mirror_span = 1;
		while (mirror_span < n)
			mirror_span = mirror_span << 1;
		for (int i = 0; i < TREE_WORDS; i++)
			mirror_nodes[i] = '0;
	endfunction

	// write one leaf and rebuild its ancestors
	function automatic void store_leaf(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		int node;
		if (pos < 1 || pos > mirror_span)
			return;
		node = pos + mirror_span - 1;
		mirror_nodes[node] = val;
		while (node >= 2) begin
			node = node >> 1;
			mirror_nodes[node] = mirror_nodes[2 * node] + mirror_nodes[2 * node + 1];
		end
	endfunction

	// wrapping sum over [lo_pos, hi_pos) after clipping the bounds
	function automatic logic [VAL_W-1:0] range_total(input logic [POS_W-1:0] lo_pos,
			input logic [POS_W-1:0] hi_pos);
		logic [VAL_W-1:0] acc;
		int lo;
		int hi;
		acc = '0;
		lo = int'(lo_pos);
		hi = int'(hi_pos);
		if (lo < 1)
			lo = 1;
		if (hi > mirror_span + 1)
			hi = mirror_span + 1;
		if (lo >= hi)
			return '0;
		lo = lo + mirror_span - 1;
		hi = hi + mirror_span - 1;
		while (lo < hi) begin
			if (lo % 2 == 1) begin
				acc = acc + mirror_nodes[lo];
				lo++;
			end
			if (hi % 2 == 1) begin
				hi--;
				acc = acc + mirror_nodes[hi];
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	function automatic seg_req_t mk_row(input logic op, input int pos, input logic [VAL_W-1:0] val,
			input int lo, input int hi, input bit typed, input logic [VAL_W-1:0] sum);
		seg_req_t r;
		r.op    = op;
		r.pos   = pos[POS_W-1:0];
		r.val   = val;
		r.lo    = lo[POS_W-1:0];
		r.hi    = hi[POS_W-1:0];
		r.typed = typed;
		r.sum   = sum;
		return r;
	endfunction

	// offer one beat after a random gap, then update the mirror on acceptance
	task automatic drive_item(input seg_req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.op;
		s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, r.hi, r.lo, r.val, r.pos};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (r.op == OP_SET) begin
			store_leaf(r.pos, r.val);
			n_sets++;
		end else begin
			pending_sums.push_back(r.typed ? r.sum : range_total(r.lo, r.hi));
			n_queries++;
		end
	endtask

	// drop valid and hold until every outstanding sum has come back
	task automatic drain_sums();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
	endtask

	// write the leaf count once the block is quiet
	task automatic write_leaf_count(input logic [CNT_W-1:0] cnt);
		drain_sums();
		repeat (TAIL_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cnt;
		@(negedge clk);
		cfg_we <= 1'b0;
		load_leaf_count(cnt);
		n_cfg++;
	endtask

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// compare every accepted sum with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$error("range_sum: unexpected beat, actual %0d", $signed(m_tdata));
				n_fail++;
			end else begin
				if (m_tdata !== pending_sums[0]) begin
					$error("range_sum mismatch: expected %0d, actual %0d",
						$signed(pending_sums[0]), $signed(m_tdata));
					n_fail++;
				end
				void'(pending_sums.pop_front());
				n_checked++;
			end
		end
	end

	initial begin
		seg_req_t rq;
		int roll;
		int pick;
		int lc;

		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = OP_SET;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		idle_pct      = 0;
		stall_pct     = 0;
		long_hold_req = 1'b0;
		n_fail        = 0;
		n_sets        = 0;
		n_queries     = 0;
		n_checked     = 0;
		n_cfg         = 0;
		load_leaf_count(CNT_W'(CNT_RESET));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed rows at the reset span of 1024 leaves
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 1, 1025, 1, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 2047, 32'hFFFF_FFFF, 0, 2047, 1, 0));
		dir_rows.push_back(mk_row(OP_SET, 1, 32'h7FFF_FFFF, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_SET, 1024, 32'h8000_0000, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_SET, 0, 32'h0001_2345, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_SET, 1025, 32'h0000_0055, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_SET, 2047, 32'hFFFF_FFFF, 2047, 2047, 0, 0));
		dir_rows.push_back(mk_row(OP_SET, 512, 32'hFFFF_FFFF, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 1, 1025, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 2, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 1024, 2047, 0, 0));
		// empty ranges: equal bounds, reversed bounds, start past the span, clipped empty
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 5, 5, 1, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 2047, 0, 1, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 1025, 2047, 1, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 1, 1, 0));
		dir_rows.push_back(mk_row(OP_SET, 1, 32'h0000_0000, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 1, 2, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 0, 0, 512, 513, 0, 0));
		dir_rows.push_back(mk_row(OP_SET, 1023, 32'h1234_5678, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 1365, 32'h5555_5555, 1000, 1025, 0, 0));
		dir_rows.push_back(mk_row(OP_QUERY, 682, 32'hAAAA_AAAA, 1, 1024, 0, 0));
		foreach (dir_rows[i])
			drive_item(dir_rows[i]);

		// random phases over several leaf counts and idle patterns
		for (int ph = 0; ph < N_PHASES; ph++) begin
			lc = (ph_lc[ph] < 0) ? $urandom_range(2, 1023) : ph_lc[ph];
			write_leaf_count(lc[CNT_W-1:0]);
			idle_pct  = ph_idle[ph];
			stall_pct = ph_stall[ph];
			// fill the block against a long receiver hold-off once the clear is done
			if (ph == 0 || ph == 5) begin
				@(posedge clk);
				while (!s_tready)
					@(posedge clk);
				long_hold_req = 1'b1;
			end
			for (int k = 0; k < ph_items[ph]; k++) begin
				if (k == ph_items[ph] / 2)
					drain_sums();
				rq.op = 1'($urandom_range(0, 1));
				roll = $urandom_range(0, 99);
				pick = $urandom_range(0, 9);
				case (pick)
					0: rq.val = 32'h8000_0000;
					1: rq.val = 32'h7FFF_FFFF;
					2: rq.val = 32'h0000_0000;
					3: rq.val = 32'hFFFF_FFFF;
					default: rq.val = $urandom;
				endcase
				// mostly in-range positions and well-formed ranges, some raw noise
				if (roll < 80) begin
					rq.pos = POS_W'($urandom_range(1, mirror_span));
					rq.lo  = POS_W'($urandom_range(1, mirror_span));
					rq.hi  = POS_W'($urandom_range(rq.lo, mirror_span + 1));
				end else begin
					rq.pos = POS_W'($urandom_range(0, 2047));
					rq.lo  = POS_W'($urandom_range(0, 2047));
					rq.hi  = POS_W'($urandom_range(0, 2047));
				end
				rq.typed = 1'b0;
				rq.sum   = '0;
				drive_item(rq);
			end
		end

		// let the last results and any trailing update finish
		drain_sums();
		repeat (TAIL_WAIT) @(negedge clk);

		$display("Covered %0d updates and %0d range queries across %0d leaf-count writes",
			n_sets, n_queries, n_cfg);
		$display("with idle, stall and long hold-off phases; %0d sums compared.", n_checked);
		if (n_fail == 0 && pending_sums.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
